// ===== src/esd_pkg.sv =====
// Shared types, character codes and helpers for the escaped string decoder.
`default_nettype none

package esd_pkg;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 4;

  // Largest number of decoded bytes one input character can produce.
  localparam int unsigned MaxBytes = 3;

  // Characters recognized after a backslash.
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharQuote  = 8'h22;

  // Decoded control bytes.
  localparam logic [7:0] ByteCr  = 8'h0D;
  localparam logic [7:0] ByteLf  = 8'h0A;
  localparam logic [7:0] ByteTab = 8'h09;
  localparam logic [7:0] ByteBs  = 8'h08;
  localparam logic [7:0] ByteNul = 8'h00;

  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX1   = 2'd2,
    MODE_HEX2   = 2'd3
  } mode_e;

  // One decoded command: up to three bytes, how many, and end of string.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] data;
    logic [1:0]               num;
    logic                     last;
  } cmd_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/esd_in_if.sv =====
// Input channel: one escaped character per transfer.
`default_nettype none

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

// ===== src/esd_out_if.sv =====
// Output channel: one decoded byte per transfer.
`default_nettype none

interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] out_count;

  modport source (output valid, output out_byte, output out_last, output out_count,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/esd_front.sv =====
// Front end: tracks the escape state and turns each character into a command.
`default_nettype none

module esd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  esd_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output esd_pkg::cmd_t cmd_o
);

  esd_pkg::mode_e mode_q, mode_d;
  logic [7:0]     held_q, held_d;
  logic           accept;
  logic           tail;
  logic [4:0]     lo_nib;
  logic [4:0]     hi_nib;
  esd_pkg::cmd_t  cmd;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the character against the current mode.
  always_comb begin
    cmd    = '0;
    mode_d = mode_q;
    held_d = held_q;
    // a plain character emits unless it opens a new escape
    tail   = (in_i.in_char != esd_pkg::CharBslash) || in_i.in_last;
    lo_nib = esd_pkg::nibble_of(in_i.in_char);
    hi_nib = esd_pkg::nibble_of(held_q);
    case (mode_q)
      esd_pkg::MODE_ESC: begin
        mode_d = esd_pkg::MODE_NORMAL;
        cmd.num = 2'd1;
        case (in_i.in_char)
          esd_pkg::CharR:      cmd.data[0] = esd_pkg::ByteCr;
          esd_pkg::CharN:      cmd.data[0] = esd_pkg::ByteLf;
          esd_pkg::CharT:      cmd.data[0] = esd_pkg::ByteTab;
          esd_pkg::CharB:      cmd.data[0] = esd_pkg::ByteBs;
          esd_pkg::CharQuote:  cmd.data[0] = esd_pkg::CharQuote;
          esd_pkg::CharBslash: cmd.data[0] = esd_pkg::CharBslash;
          esd_pkg::CharZero:   cmd.data[0] = esd_pkg::ByteNul;
          esd_pkg::CharX: begin
            if (in_i.in_last) begin
              cmd.data[0] = esd_pkg::CharX;
            end else begin
              cmd.num = 2'd0;
              mode_d  = esd_pkg::MODE_HEX1;
            end
          end
          default: begin
            // unknown escape keeps its backslash
            cmd.data[0] = esd_pkg::CharBslash;
            cmd.data[1] = in_i.in_char;
            cmd.num     = 2'd2;
          end
        endcase
      end
      esd_pkg::MODE_HEX1: begin
        if (lo_nib[4] && !in_i.in_last) begin
          held_d = in_i.in_char;
          mode_d = esd_pkg::MODE_HEX2;
        end else begin
          cmd.data[0] = esd_pkg::CharX;
          cmd.data[1] = in_i.in_char;
          cmd.num     = tail ? 2'd2 : 2'd1;
          mode_d      = tail ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_ESC;
        end
      end
      esd_pkg::MODE_HEX2: begin
        if (lo_nib[4] && hi_nib[4]) begin
          cmd.data[0] = {hi_nib[3:0], lo_nib[3:0]};
          cmd.num     = 2'd1;
          mode_d      = esd_pkg::MODE_NORMAL;
        end else begin
          cmd.data[0] = esd_pkg::CharX;
          cmd.data[1] = held_q;
          cmd.data[2] = in_i.in_char;
          cmd.num     = tail ? 2'd3 : 2'd2;
          mode_d      = tail ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_ESC;
        end
      end
      default: begin
        cmd.data[0] = in_i.in_char;
        cmd.num     = tail ? 2'd1 : 2'd0;
        mode_d      = tail ? esd_pkg::MODE_NORMAL : esd_pkg::MODE_ESC;
      end
    endcase
    // end of string returns to the idle state
    if (in_i.in_last) begin
      mode_d = esd_pkg::MODE_NORMAL;
      held_d = 8'd0;
    end
    cmd.last = in_i.in_last;
  end

  assign push_o = accept && (cmd.num != 2'd0);
  assign cmd_o  = cmd;

  // Advance the escape state on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= esd_pkg::MODE_NORMAL;
      held_q <= 8'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.in_last |=> mode_q == esd_pkg::MODE_NORMAL && held_q == 8'd0)
    else $error("escape state not cleared after end of string");

  a_last_always_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.in_last |-> push_o)
    else $error("end of string produced no bytes");

endmodule

`default_nettype wire

// ===== src/esd_fifo.sv =====
// Command queue between the front end and the byte emitter.
`default_nettype none

module esd_fifo #(
  parameter int unsigned Depth = esd_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  esd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output esd_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  esd_pkg::cmd_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full command queue");

endmodule

`default_nettype wire

// ===== src/esd_back.sv =====
// Back end: emits command bytes one per cycle unless out_o stalls; counts them.
`default_nettype none

module esd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  esd_pkg::cmd_t head_i,
  output logic          pop_o,
  esd_out_if.source     out_o
);

  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic [15:0] out_count_q;
  logic [15:0] count_q, count_d;
  logic [1:0]  idx_q, idx_d;
  logic [15:0] count_inc;
  logic        head_valid;
  logic        load;
  logic        last_byte;

  assign head_valid = !q_empty_i;
  assign load       = head_valid && (!out_valid_q || out_o.ready);
  assign last_byte  = (idx_q == head_i.num - 2'd1);
  assign count_inc  = (count_q == esd_pkg::CountMax) ? count_q : count_q + 16'd1;
  assign pop_o      = load && last_byte;

  // Pick the next byte and step through the command.
  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    out_byte_d = head_i.data[idx_q];
    out_last_d = head_i.last && last_byte;
    if (load) begin
      if (last_byte) begin
        idx_d   = 2'd0;
        count_d = head_i.last ? 16'd0 : count_inc;
      end else begin
        idx_d   = idx_q + 2'd1;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      count_q     <= 16'd0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the output payload while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_count_q <= count_inc;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_last  = out_last_q;
  assign out_o.out_count = out_count_q;

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_count_q != 16'd0)
    else $error("decoded byte carries a zero count");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> head_i.num != 2'd0 && idx_q < head_i.num)
    else $error("byte index beyond command length");

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid |-> idx_q == 2'd0)
    else $error("byte index left mid-command with empty queue");

endmodule

`default_nettype wire

// ===== src/escaped_string_decoder_top.sv =====
// Top level of the escaped string decoder.
//
// Input channel in_i carries one character of an escaped string per transfer,
// with in_last on the final character. Output channel out_o carries decoded
// bytes, out_last on the final byte of each string and out_count, the number
// of bytes of the string so far including this one, saturating at 65535.
// Escapes \r \n \t \b \" \\ \0 and \xHH decode to one byte; a broken hex
// escape yields 'x' and the rest as plain characters; unknown escapes keep
// their backslash.
// Bytes reach out_o through the command queue and the output register.
// Throughput: one character per cycle while each yields at most one byte and
// the receiver is ready; the single-byte emitter steps through a character's
// two or three bytes while the command queue (QueueDepth entries) absorbs
// this. The emitter outputs one byte per cycle while out_o is ready.
// Reset clears the escape state, the queue, the count and the output valid.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_i.ready drops once the queue is full.
`default_nettype none

module escaped_string_decoder_top #(
  parameter int unsigned QueueDepth = esd_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  esd_in_if.sink    in_i,
  esd_out_if.source out_o
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  esd_pkg::cmd_t cmd;
  esd_pkg::cmd_t head;

  esd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  esd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  esd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
